@@ sv/wiep_pkg.sv @@
`timescale 1ns / 1ps
package wiep_pkg;

  localparam int BLOCK_W = 11;
  localparam int SSID_MAX = 32;
  localparam int ROWS = 3;

  localparam logic [23:0] OUI_MS = 24'h0050F2;
  localparam logic [23:0] OUI_IEEE = 24'h000FAC;

  localparam logic [7:0] ET_SSID = 8'd0;
  localparam logic [7:0] ET_HT = 8'd61;
  localparam logic [7:0] ET_VHT = 8'd192;
  localparam logic [7:0] ET_RSN = 8'd48;

  // element walk phases
  localparam logic [1:0] PH_TYPE = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;
  localparam logic [1:0] PH_ENDED = 2'd3;

  // rsn parse phases
  localparam logic [2:0] RS_IDLE = 3'd0;
  localparam logic [2:0] RS_VERSION = 3'd1;
  localparam logic [2:0] RS_GROUP = 3'd2;
  localparam logic [2:0] RS_PCOUNT = 3'd3;
  localparam logic [2:0] RS_PLIST = 3'd4;
  localparam logic [2:0] RS_ACOUNT = 3'd5;
  localparam logic [2:0] RS_ALIST = 3'd6;
  localparam logic [2:0] RS_STOP = 3'd7;

  // report kinds
  localparam logic [3:0] K_SSID_START = 4'd0;
  localparam logic [3:0] K_SSID_CHAR = 4'd1;
  localparam logic [3:0] K_HT = 4'd2;
  localparam logic [3:0] K_VHT = 4'd3;
  localparam logic [3:0] K_RSN_START = 4'd4;
  localparam logic [3:0] K_GROUP = 4'd5;
  localparam logic [3:0] K_PAIRWISE = 4'd6;
  localparam logic [3:0] K_AUTH = 4'd7;
  localparam logic [3:0] K_GROUP_DEF = 4'd8;
  localparam logic [3:0] K_PAIR_DEF = 4'd9;
  localparam logic [3:0] K_AUTH_DEF = 4'd10;

  localparam logic [4:0] NAME_UNKNOWN = 5'd8;
  localparam logic [4:0] NAME_RAW = 5'd16;

  typedef struct packed {
    logic [BLOCK_W-1:0] block_left;
    logic [1:0]  elem_phase;
    logic [7:0]  elem_type;
    logic [7:0]  elem_len;
    logic [7:0]  body_pos;
    logic [2:0]  rsn_phase;
    logic [15:0] list_count;
    logic [15:0] list_pos;
    logic [23:0] suite_bytes;
    logic        ssid_done;
  } walk_t;

  typedef struct packed {
    logic [3:0]  report_kind;
    logic [7:0]  ssid_char;
    logic [4:0]  ssid_pos;
    logic        ht_wide;
    logic [1:0]  ht_offset;
    logic [7:0]  vht_width;
    logic [7:0]  vht_center1;
    logic [7:0]  vht_center2;
    logic [23:0] suite_oui;
    logic [7:0]  suite_type;
    logic [4:0]  suite_name;
    logic        last_of_run;
  } row_t;

  function automatic logic [4:0] cipher_name(input logic [23:0] oui, input logic [7:0] t);
    logic [4:0] r;
    r = NAME_UNKNOWN;
    if (oui == OUI_MS) begin
      unique case (t)
        8'd0: r = 5'd0;
        8'd1: r = 5'd1;
        8'd2: r = 5'd2;
        8'd3: r = 5'd8;
        8'd4: r = 5'd3;
        8'd5: r = 5'd4;
        default: r = NAME_UNKNOWN;
      endcase
    end else if (oui == OUI_IEEE) begin
      unique case (t)
        8'd0: r = 5'd0;
        8'd1: r = 5'd1;
        8'd2: r = 5'd2;
        8'd3: r = 5'd8;
        8'd4: r = 5'd3;
        8'd5: r = 5'd4;
        8'd6: r = 5'd5;
        8'd7: r = 5'd6;
        8'd8: r = 5'd7;
        default: r = NAME_UNKNOWN;
      endcase
    end
    return r;
  endfunction

  function automatic logic [4:0] auth_name(input logic [23:0] oui, input logic [7:0] t);
    logic [4:0] r;
    r = NAME_RAW;
    if (oui == OUI_MS) begin
      if (t == 8'd1) r = 5'd0;
      else if (t == 8'd2) r = 5'd1;
    end else if (oui == OUI_IEEE) begin
      unique case (t)
        8'd1: r = 5'd0;
        8'd2: r = 5'd1;
        8'd3: r = 5'd0;
        8'd4: r = 5'd2;
        8'd5: r = 5'd3;
        8'd6: r = 5'd4;
        8'd7: r = 5'd5;
        8'd8: r = 5'd6;
        8'd9: r = 5'd7;
        8'd11: r = 5'd8;
        8'd12: r = 5'd9;
        8'd13: r = 5'd10;
        8'd14: r = 5'd11;
        8'd15: r = 5'd12;
        8'd16: r = 5'd13;
        8'd17: r = 5'd14;
        8'd18: r = 5'd15;
        default: r = NAME_RAW;
      endcase
    end
    return r;
  endfunction

  function automatic row_t blank_row(input logic [3:0] kind);
    row_t r;
    r = '0;
    r.report_kind = kind;
    return r;
  endfunction

endpackage

@@ sv/wiep_step.sv @@
`timescale 1ns / 1ps
module wiep_step (
  input  wiep_pkg::walk_t                   cur,
  input  logic [7:0]                        ie_byte,
  input  logic                              first_of_block,
  input  logic [wiep_pkg::BLOCK_W-1:0]      block_len,
  output wiep_pkg::walk_t                   nxt,
  output wiep_pkg::row_t                    rows [wiep_pkg::ROWS],
  output logic [1:0]                        n_rows
);

  wiep_pkg::walk_t st;
  logic [1:0]  n;
  logic [7:0]  b;
  logic [7:0]  rem;
  logic [7:0]  pos_inc;
  logic [23:0] sb_col;
  logic        suite_end;
  logic [15:0] lp_inc;
  logic [15:0] cnt_full;
  logic        is_ssid;

  // one byte of the walk, up to three reports
  always_comb begin
    st = cur;
    n = 2'd0;
    b = ie_byte;
    for (int i = 0; i < wiep_pkg::ROWS; i++) rows[i] = '0;
    rem = '0;
    pos_inc = '0;
    sb_col = '0;
    suite_end = 1'b0;
    lp_inc = '0;
    cnt_full = '0;
    is_ssid = 1'b0;

    if (first_of_block) begin
      st.block_left = block_len;
      st.elem_phase = wiep_pkg::PH_TYPE;
      st.rsn_phase = wiep_pkg::RS_IDLE;
    end

    if (st.block_left != '0) begin
      unique case (st.elem_phase)
        wiep_pkg::PH_TYPE: begin
          if (st.block_left < 11'd2) begin
            st.elem_phase = wiep_pkg::PH_ENDED;
          end else begin
            st.elem_type = b;
            st.elem_phase = wiep_pkg::PH_LEN;
          end
        end
        wiep_pkg::PH_LEN: begin
          if ({3'b0, b} > st.block_left - 11'd1) begin
            st.elem_phase = wiep_pkg::PH_ENDED;
          end else begin
            st.elem_len = b;
            st.body_pos = '0;
            st.rsn_phase = wiep_pkg::RS_IDLE;
            // element start reports
            if (st.elem_type == wiep_pkg::ET_SSID && b <= 8'(wiep_pkg::SSID_MAX)) begin
              rows[n] = wiep_pkg::blank_row(wiep_pkg::K_SSID_START);
              n = n + 2'd1;
              st.ssid_done = 1'b0;
            end else if (st.elem_type == wiep_pkg::ET_RSN) begin
              rows[n] = wiep_pkg::blank_row(wiep_pkg::K_RSN_START);
              n = n + 2'd1;
              if (b < 8'd6) begin
                rows[n] = wiep_pkg::blank_row(wiep_pkg::K_GROUP_DEF);
                rows[n].suite_name = wiep_pkg::NAME_UNKNOWN;
                n = n + 2'd1;
                rows[n] = wiep_pkg::blank_row(wiep_pkg::K_PAIR_DEF);
                rows[n].suite_name = wiep_pkg::NAME_UNKNOWN;
                n = n + 2'd1;
                st.rsn_phase = wiep_pkg::RS_STOP;
              end else begin
                st.rsn_phase = wiep_pkg::RS_VERSION;
              end
            end
            st.elem_phase = (b == 8'd0) ? wiep_pkg::PH_TYPE : wiep_pkg::PH_BODY;
          end
        end
        wiep_pkg::PH_BODY: begin
          rem = st.elem_len - st.body_pos - 8'd1;
          is_ssid = (st.elem_type == wiep_pkg::ET_SSID) &&
                    (st.elem_len <= 8'(wiep_pkg::SSID_MAX));
          // suite byte collection shared by the rsn group suite and lists
          unique case (st.list_pos[1:0])
            2'd0: sb_col = {16'b0, b};
            2'd1, 2'd2: sb_col = {st.suite_bytes[15:0], b};
            default: sb_col = st.suite_bytes;
          endcase
          suite_end = (st.list_pos[1:0] == 2'd3);
          lp_inc = st.list_pos + 16'd1;
          cnt_full = {b, st.list_count[7:0]};

          if (is_ssid) begin
            if (!st.ssid_done) begin
              if (b == 8'd0) begin
                st.ssid_done = 1'b1;
              end else begin
                rows[n] = wiep_pkg::blank_row(wiep_pkg::K_SSID_CHAR);
                rows[n].ssid_char = b;
                rows[n].ssid_pos = st.body_pos[4:0];
                n = n + 2'd1;
              end
            end
          end else if (st.elem_type == wiep_pkg::ET_HT) begin
            if (st.body_pos == 8'd1) begin
              rows[n] = wiep_pkg::blank_row(wiep_pkg::K_HT);
              rows[n].ht_wide = b[2];
              rows[n].ht_offset = b[1:0];
              n = n + 2'd1;
            end
          end else if (st.elem_type == wiep_pkg::ET_VHT) begin
            if (st.body_pos == 8'd0) begin
              st.suite_bytes = {16'b0, b};
            end else if (st.body_pos == 8'd1) begin
              st.suite_bytes = {st.suite_bytes[15:0], b};
            end else if (st.body_pos == 8'd2) begin
              rows[n] = wiep_pkg::blank_row(wiep_pkg::K_VHT);
              rows[n].vht_width = st.suite_bytes[15:8];
              rows[n].vht_center1 = st.suite_bytes[7:0];
              rows[n].vht_center2 = b;
              n = n + 2'd1;
            end
          end else if (st.elem_type == wiep_pkg::ET_RSN) begin
            unique case (st.rsn_phase)
              wiep_pkg::RS_VERSION: begin
                if (st.body_pos == 8'd1) begin
                  st.rsn_phase = wiep_pkg::RS_GROUP;
                  st.list_pos = '0;
                end
              end
              wiep_pkg::RS_GROUP: begin
                st.suite_bytes = sb_col;
                st.list_pos = lp_inc;
                if (suite_end) begin
                  rows[n] = wiep_pkg::blank_row(wiep_pkg::K_GROUP);
                  rows[n].suite_oui = sb_col;
                  rows[n].suite_type = b;
                  rows[n].suite_name = wiep_pkg::cipher_name(sb_col, b);
                  n = n + 2'd1;
                  if (rem < 8'd2) begin
                    rows[n] = wiep_pkg::blank_row(wiep_pkg::K_PAIR_DEF);
                    rows[n].suite_name = wiep_pkg::NAME_UNKNOWN;
                    n = n + 2'd1;
                    st.rsn_phase = wiep_pkg::RS_STOP;
                  end else begin
                    st.rsn_phase = wiep_pkg::RS_PCOUNT;
                    st.list_pos = '0;
                  end
                end
              end
              wiep_pkg::RS_PCOUNT, wiep_pkg::RS_ACOUNT: begin
                if (st.list_pos == '0) begin
                  st.list_count = {8'b0, b};
                  st.list_pos = 16'd1;
                end else begin
                  st.list_count = cnt_full;
                  st.list_pos = '0;
                  if ({cnt_full, 2'b00} > {10'b0, rem}) begin
                    st.rsn_phase = wiep_pkg::RS_STOP;
                  end else if (cnt_full == '0) begin
                    if (st.rsn_phase == wiep_pkg::RS_PCOUNT && rem >= 8'd2) begin
                      st.rsn_phase = wiep_pkg::RS_ACOUNT;
                    end else if (st.rsn_phase == wiep_pkg::RS_PCOUNT) begin
                      rows[n] = wiep_pkg::blank_row(wiep_pkg::K_AUTH_DEF);
                      rows[n].suite_name = wiep_pkg::NAME_RAW;
                      n = n + 2'd1;
                      st.rsn_phase = wiep_pkg::RS_STOP;
                    end else begin
                      st.rsn_phase = wiep_pkg::RS_STOP;
                    end
                  end else begin
                    st.rsn_phase = (st.rsn_phase == wiep_pkg::RS_PCOUNT) ?
                                   wiep_pkg::RS_PLIST : wiep_pkg::RS_ALIST;
                  end
                end
              end
              wiep_pkg::RS_PLIST, wiep_pkg::RS_ALIST: begin
                st.suite_bytes = sb_col;
                st.list_pos = lp_inc;
                if (suite_end) begin
                  if (st.rsn_phase == wiep_pkg::RS_PLIST) begin
                    rows[n] = wiep_pkg::blank_row(wiep_pkg::K_PAIRWISE);
                    rows[n].suite_name = wiep_pkg::cipher_name(sb_col, b);
                  end else begin
                    rows[n] = wiep_pkg::blank_row(wiep_pkg::K_AUTH);
                    rows[n].suite_name = wiep_pkg::auth_name(sb_col, b);
                  end
                  rows[n].suite_oui = sb_col;
                  rows[n].suite_type = b;
                  n = n + 2'd1;
                  if ({2'b0, lp_inc[15:2]} >= st.list_count) begin
                    if (st.rsn_phase == wiep_pkg::RS_PLIST && rem >= 8'd2) begin
                      st.rsn_phase = wiep_pkg::RS_ACOUNT;
                      st.list_pos = '0;
                    end else if (st.rsn_phase == wiep_pkg::RS_PLIST) begin
                      rows[n] = wiep_pkg::blank_row(wiep_pkg::K_AUTH_DEF);
                      rows[n].suite_name = wiep_pkg::NAME_RAW;
                      n = n + 2'd1;
                      st.rsn_phase = wiep_pkg::RS_STOP;
                    end else begin
                      st.rsn_phase = wiep_pkg::RS_STOP;
                    end
                  end
                end
              end
              default: ;
            endcase
          end

          pos_inc = st.body_pos + 8'd1;
          st.body_pos = pos_inc;
          if (pos_inc >= st.elem_len) st.elem_phase = wiep_pkg::PH_TYPE;
        end
        default: ;
      endcase
      st.block_left = st.block_left - 11'd1;
    end

    // mark the final report of this byte
    if (n != 2'd0) rows[n - 2'd1].last_of_run = 1'b1;

    nxt = st;
    n_rows = n;
  end

endmodule

@@ sv/wiep_outq.sv @@
`timescale 1ns / 1ps
module wiep_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wiep_pkg::row_t   push_rows [wiep_pkg::ROWS],
  input  logic [1:0]       push_n,
  output logic             room,
  output logic             head_valid,
  input  logic             head_ready,
  output wiep_pkg::row_t   head
);

  wiep_pkg::row_t slot [wiep_pkg::ROWS];
  logic [1:0] cnt;
  logic       pop;

  assign pop = head_valid && head_ready;
  // room when empty, or when the single remaining result drains this cycle
  assign room = (cnt == 2'd0) || (cnt == 2'd1 && head_ready);
  assign head_valid = (cnt != 2'd0);
  assign head = slot[0];

  // result slots, drained from slot 0
  always_ff @(posedge clk) begin
    if (push) begin
      slot <= push_rows;
    end else if (pop) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (push) begin
      cnt <= push_n;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    push |-> (cnt == 2'd0 || (cnt == 2'd1 && pop)))
    else $error("results pushed over undelivered ones");

  a_single_is_last: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd1) |-> head.last_of_run)
    else $error("lone remaining result not marked last");

  a_push_loads: assert property (@(posedge clk) disable iff (rst)
    push |=> (cnt == $past(push_n)))
    else $error("occupancy does not match pushed count");

endmodule

@@ sv/wlan_info_element_parser_core.sv @@
`timescale 1ns / 1ps
// Information element parser: takes one byte of an 802.11 element block per
// accepted word and reports SSID, HT, VHT and RSN suites. The walk state
// updates in the same cycle the byte is accepted. A byte makes zero to three
// reports, and the three-slot result buffer drains one report per cycle while
// m_tready is high; the input is held until all but the last report of the
// previous byte have drained, and bytes with no report stream at one per
// cycle once the buffer is empty.
module wlan_info_element_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // ie_byte[7:0], block_len[18:8], zero pad
  input  logic [0:0]  s_tuser,   // first_of_block
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // ssid_char, ssid_pos, ht_wide, ht_offset, vht_width,
                                 // vht_center1, vht_center2, suite_oui, suite_type,
                                 // suite_name, zero pad
  output logic [3:0]  m_tuser,   // report_kind
  output logic        m_tlast    // last_of_run
);

  wiep_pkg::walk_t walk;
  wiep_pkg::walk_t walk_next;
  wiep_pkg::row_t  rows [wiep_pkg::ROWS];
  wiep_pkg::row_t  head;
  logic [1:0]      n_rows;
  logic            room;
  logic            accept;

  assign s_tready = room;
  assign accept = s_tvalid && s_tready;

  wiep_step u_step (
    .cur            (walk),
    .ie_byte        (s_tdata[7:0]),
    .first_of_block (s_tuser[0]),
    .block_len      (s_tdata[18:8]),
    .nxt            (walk_next),
    .rows           (rows),
    .n_rows         (n_rows)
  );

  // walk state
  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (accept) begin
      walk <= walk_next;
    end
  end

  wiep_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_rows  (rows),
    .push_n     (n_rows),
    .room       (room),
    .head_valid (m_tvalid),
    .head_ready (m_tready),
    .head       (head)
  );

  // output word packing
  assign m_tdata = {3'b000, head.suite_name, head.suite_type, head.suite_oui,
                    head.vht_center2, head.vht_center1, head.vht_width,
                    head.ht_offset, head.ht_wide, head.ssid_pos, head.ssid_char};
  assign m_tuser = head.report_kind;
  assign m_tlast = head.last_of_run;

endmodule

@@ tb/info_element_checker.sv @@
`timescale 1ns / 1ps
// watches both streams, predicts the reports of each accepted byte and
// compares every accepted result word against the oldest prediction
module info_element_checker
  import wiep_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,
  input  logic [3:0]  m_tuser,
  input  logic        m_tlast,
  output int          failures,
  output int          pending
);

  // suite name tables, indexed by suite type
  localparam logic [4:0] IEEE_CIPHER [9] = '{0, 1, 2, 8, 3, 4, 5, 6, 7};
  localparam logic [4:0] IEEE_AUTH [19] =
    '{16, 0, 1, 0, 2, 3, 4, 5, 6, 7, 16, 8, 9, 10, 11, 12, 13, 14, 15};

  // walker copy
  int          left_bytes;
  logic [1:0]  walk_ph;
  logic [7:0]  etype;
  logic [7:0]  elen;
  logic [7:0]  bpos;
  logic [2:0]  rph;
  int          lcount;
  int          lpos;
  logic [23:0] sbytes;
  bit          ssid_over;

  row_t reports [3];
  int   nrep;
  row_t expected_reports [$];

  assign pending = expected_reports.size();

  function automatic logic [4:0] cipher_of(input logic [23:0] oui, input logic [7:0] t);
    if (oui == OUI_MS && t < 6) return IEEE_CIPHER[t];
    if (oui == OUI_IEEE && t < 9) return IEEE_CIPHER[t];
    return NAME_UNKNOWN;
  endfunction

  function automatic logic [4:0] auth_of(input logic [23:0] oui, input logic [7:0] t);
    if (oui == OUI_MS) return (t == 1) ? 5'd0 : (t == 2) ? 5'd1 : NAME_RAW;
    if (oui == OUI_IEEE && t < 19) return IEEE_AUTH[t];
    return NAME_RAW;
  endfunction

  task automatic add_report(input logic [3:0] kind);
    if (nrep >= 3) nrep = 2;
    reports[nrep] = '0;
    reports[nrep].report_kind = kind;
    nrep++;
  endtask

  task automatic add_suite(input logic [3:0] kind, input logic [7:0] t);
    add_report(kind);
    reports[nrep-1].suite_oui = sbytes;
    reports[nrep-1].suite_type = t;
    reports[nrep-1].suite_name = (kind == K_AUTH) ? auth_of(sbytes, t) : cipher_of(sbytes, t);
  endtask

  task automatic add_default(input logic [3:0] kind);
    add_report(kind);
    reports[nrep-1].suite_name = (kind == K_AUTH_DEF) ? NAME_RAW : NAME_UNKNOWN;
  endtask

  // true when this byte completes a suite
  function automatic bit take_suite_byte(input logic [7:0] b);
    int idx;
    idx = lpos & 3;
    if (idx == 0) sbytes = {16'd0, b};
    else if (idx < 3) sbytes = {sbytes[15:0], b};
    lpos = (lpos + 1) & 16'hffff;
    return idx == 3;
  endfunction

  task automatic end_of_pairwise(input int rem);
    if (rem < 2) begin
      add_default(K_AUTH_DEF);
      rph = RS_STOP;
    end else begin
      rph = RS_ACOUNT;
      lpos = 0;
    end
  endtask

  task automatic rsn_step(input logic [7:0] b, input int rem);
    bit pw;
    case (rph)
      RS_VERSION: begin
        if (bpos == 1) begin
          rph = RS_GROUP;
          lpos = 0;
        end
      end
      RS_GROUP: begin
        if (take_suite_byte(b)) begin
          add_suite(K_GROUP, b);
          if (rem < 2) begin
            add_default(K_PAIR_DEF);
            rph = RS_STOP;
          end else begin
            rph = RS_PCOUNT;
            lpos = 0;
          end
        end
      end
      RS_PCOUNT, RS_ACOUNT: begin
        if (lpos == 0) begin
          lcount = b;
          lpos = 1;
        end else begin
          lcount = lcount | (int'(b) << 8);
          lpos = 0;
          if (lcount * 4 > rem) rph = RS_STOP;
          else if (lcount == 0) begin
            if (rph == RS_PCOUNT) end_of_pairwise(rem);
            else rph = RS_STOP;
          end else rph = (rph == RS_PCOUNT) ? RS_PLIST : RS_ALIST;
        end
      end
      RS_PLIST, RS_ALIST: begin
        if (take_suite_byte(b)) begin
          pw = (rph == RS_PLIST);
          add_suite(pw ? K_PAIRWISE : K_AUTH, b);
          if ((lpos >> 2) >= lcount) begin
            if (pw) end_of_pairwise(rem);
            else rph = RS_STOP;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic body_step(input logic [7:0] b);
    int rem;
    rem = int'(elen) - int'(bpos) - 1;
    if (etype == ET_SSID && elen <= SSID_MAX) begin
      if (!ssid_over) begin
        if (b == 0) ssid_over = 1;
        else begin
          add_report(K_SSID_CHAR);
          reports[nrep-1].ssid_char = b;
          reports[nrep-1].ssid_pos = bpos[4:0];
        end
      end
    end else if (etype == ET_HT) begin
      if (bpos == 1) begin
        add_report(K_HT);
        reports[nrep-1].ht_wide = b[2];
        reports[nrep-1].ht_offset = b[1:0];
      end
    end else if (etype == ET_VHT) begin
      if (bpos == 0) sbytes = {16'd0, b};
      else if (bpos == 1) sbytes = {sbytes[15:0], b};
      else if (bpos == 2) begin
        add_report(K_VHT);
        reports[nrep-1].vht_width = sbytes[15:8];
        reports[nrep-1].vht_center1 = sbytes[7:0];
        reports[nrep-1].vht_center2 = b;
      end
    end else if (etype == ET_RSN) begin
      rsn_step(b, rem);
    end
  endtask

  // expected reports of one accepted byte
  task automatic predict_byte(input logic [7:0] b, input bit first, input logic [10:0] blen);
    nrep = 0;
    if (first) begin
      left_bytes = blen;
      walk_ph = PH_TYPE;
      rph = RS_IDLE;
    end
    if (left_bytes == 0) return;
    case (walk_ph)
      PH_TYPE: begin
        if (left_bytes < 2) walk_ph = PH_ENDED;
        else begin
          etype = b;
          walk_ph = PH_LEN;
        end
      end
      PH_LEN: begin
        if (int'(b) > left_bytes - 1) walk_ph = PH_ENDED;
        else begin
          elen = b;
          bpos = 0;
          rph = RS_IDLE;
          if (etype == ET_SSID && elen <= SSID_MAX) begin
            add_report(K_SSID_START);
            ssid_over = 0;
          end else if (etype == ET_RSN) begin
            add_report(K_RSN_START);
            if (elen < 6) begin
              add_default(K_GROUP_DEF);
              add_default(K_PAIR_DEF);
              rph = RS_STOP;
            end else rph = RS_VERSION;
          end
          walk_ph = (b == 0) ? PH_TYPE : PH_BODY;
        end
      end
      PH_BODY: begin
        body_step(b);
        bpos = bpos + 1;
        if (bpos >= elen) walk_ph = PH_TYPE;
      end
      default: ;
    endcase
    left_bytes--;
    if (nrep > 0) reports[nrep-1].last_of_run = 1;
    for (int i = 0; i < nrep; i++) expected_reports.push_back(reports[i]);
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endtask

  // predict on input words first, then compare output words
  always @(posedge clk) begin
    row_t want;
    if (rst) begin
      left_bytes = 0;
      walk_ph = PH_TYPE;
      etype = 0;
      elen = 0;
      bpos = 0;
      rph = RS_IDLE;
      lcount = 0;
      lpos = 0;
      sbytes = 0;
      ssid_over = 0;
      expected_reports.delete();
    end else begin
      if (s_tvalid && s_tready) predict_byte(s_tdata[7:0], s_tuser[0], s_tdata[18:8]);
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          $error("result word with no expected report, kind %0d", m_tuser);
          failures++;
        end else begin
          want = expected_reports.pop_front();
          check_field("report_kind", want.report_kind, m_tuser);
          check_field("ssid_char", want.ssid_char, m_tdata[7:0]);
          check_field("ssid_pos", want.ssid_pos, m_tdata[12:8]);
          check_field("ht_wide", want.ht_wide, m_tdata[13]);
          check_field("ht_offset", want.ht_offset, m_tdata[15:14]);
          check_field("vht_width", want.vht_width, m_tdata[23:16]);
          check_field("vht_center1", want.vht_center1, m_tdata[31:24]);
          check_field("vht_center2", want.vht_center2, m_tdata[39:32]);
          check_field("suite_oui", want.suite_oui, m_tdata[63:40]);
          check_field("suite_type", want.suite_type, m_tdata[71:64]);
          check_field("suite_name", want.suite_name, m_tdata[76:72]);
          check_field("last_of_run", want.last_of_run, m_tlast);
        end
      end
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import wiep_pkg::*;

  localparam int ITEMS = 220;
  localparam int QUIET_TAIL = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 5000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // ie_byte[7:0], block_len[18:8], zero pad
  logic [0:0]  s_tuser;   // first_of_block
  logic        m_tvalid;
  logic        m_tready;
  logic [79:0] m_tdata;   // ssid_char .. suite_name, zero pad
  logic [3:0]  m_tuser;   // report_kind
  logic        m_tlast;   // last_of_run

  int failures;
  int pending;
  int bytes_sent;
  int stall_cycles;
  bit idle_on;
  bit hold_req;
  bit hold_done;
  logic [7:0] block_bytes [$];

  wlan_info_element_parser_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  info_element_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast), .failures(failures), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: random stall bursts and one long hold-off
  initial begin
    m_tready = 0;
    hold_done = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_tready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_tready = 0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end else begin
        m_tready = 1;
        @(negedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input bit first, input logic [10:0] blen);
    if (idle_on && $urandom_range(0, 9) == 0) begin
      s_tvalid = 0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_tvalid = 1;
    s_tdata = {5'd0, blen, b};
    s_tuser = first;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // first byte carries the declared length
  task automatic send_block(input logic [10:0] declared);
    foreach (block_bytes[i]) send_byte(block_bytes[i], i == 0, (i == 0) ? declared : 11'($urandom));
    block_bytes.delete();
  endtask

  task automatic put_element(input logic [7:0] etype, input logic [7:0] body [$], input int len);
    block_bytes.push_back(etype);
    block_bytes.push_back(8'(len));
    for (int i = 0; i < len; i++) block_bytes.push_back(body[i]);
  endtask

  task automatic put_suite(ref logic [7:0] body [$]);
    logic [23:0] oui;
    case ($urandom_range(0, 2))
      0: oui = OUI_MS;
      1: oui = OUI_IEEE;
      default: oui = 24'($urandom);
    endcase
    body.push_back(oui[23:16]);
    body.push_back(oui[15:8]);
    body.push_back(oui[7:0]);
    body.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 20)));
  endtask

  task automatic put_rsn();
    logic [7:0] body [$];
    int npw, nau, cnt, len;
    npw = $urandom_range(0, 3);
    nau = $urandom_range(0, 3);
    body.push_back(8'd1);
    body.push_back(8'd0);
    put_suite(body);
    // counts are sometimes wrong to reach the overrun case
    cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : npw;
    body.push_back(8'(cnt));
    body.push_back(8'(cnt >> 8));
    repeat (npw) put_suite(body);
    cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : nau;
    body.push_back(8'(cnt));
    body.push_back(8'(cnt >> 8));
    repeat (nau) put_suite(body);
    repeat ($urandom_range(0, 2)) body.push_back(8'($urandom));
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, body.size()) : body.size();
    put_element(ET_RSN, body, len);
  endtask

  task automatic put_random_element();
    logic [7:0] body [$];
    int len;
    case ($urandom_range(0, 5))
      0: begin
        len = $urandom_range(0, 33);
        repeat (len) body.push_back(($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom));
        put_element(ET_SSID, body, len);
      end
      1: begin
        len = $urandom_range(0, 4);
        repeat (len) body.push_back(8'($urandom));
        put_element(ET_HT, body, len);
      end
      2: begin
        len = $urandom_range(0, 5);
        repeat (len) body.push_back(8'($urandom));
        put_element(ET_VHT, body, len);
      end
      3, 4: put_rsn();
      default: begin
        len = $urandom_range(0, 6);
        repeat (len) body.push_back(8'($urandom));
        put_element(8'($urandom), body, len);
      end
    endcase
  endtask

  task automatic random_block();
    int n;
    n = $urandom_range(1, 4);
    repeat (n) put_random_element();
    case ($urandom_range(0, 9))
      0: send_block(11'($urandom_range(0, block_bytes.size())));
      1: send_block(11'(block_bytes.size() + $urandom_range(1, 3)));
      default: send_block(11'(block_bytes.size()));
    endcase
    // stray bytes outside any block
    if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 0, 11'($urandom));
  endtask

  initial begin
    logic [7:0] body [$];
    bit paused;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    idle_on = 1;
    hold_req = 0;
    paused = 0;
    bytes_sent = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // ssid with one char, ht with full bytes, rsn too short
    body = '{8'h78};
    put_element(ET_SSID, body, 1);
    body = '{8'hff, 8'hff};
    put_element(ET_HT, body, 2);
    body = '{8'h01};
    put_element(ET_RSN, body, 1);
    send_block(11'(block_bytes.size()));
    // rsn with group suite only, pairwise default follows
    body = '{8'h01, 8'h00, 8'h00, 8'h0f, 8'hac, 8'h04};
    put_element(ET_RSN, body, 6);
    send_block(11'(block_bytes.size()));
    // largest block restarted mid element
    send_byte(8'd0, 1, 11'h7ff);
    send_byte(8'd5, 0, 11'd0);
    // element longer than the block, then ignored and stray bytes
    send_byte(8'd0, 1, 11'd3);
    send_byte(8'd5, 0, 11'd0);
    send_byte(8'hff, 0, 11'd0);
    send_byte(8'h00, 0, 11'd0);
    // lone last byte
    send_byte(8'd7, 1, 11'd1);

    // random part, with one long result hold-off and one drain pause
    hold_req = 1;
    while (bytes_sent < ITEMS) begin
      if (!paused && bytes_sent > ITEMS / 2) begin
        s_tvalid = 0;
        while (pending != 0) @(negedge clk);
        paused = 1;
      end
      if (bytes_sent > ITEMS - QUIET_TAIL) idle_on = 0;
      random_block();
    end
    s_tvalid = 0;
    idle_on = 0;
    while (pending != 0 || !hold_done) @(negedge clk);
    repeat (20) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
